// ===== rtl/fdca_pkg.sv =====
// Package for the fractional-delay comb/allpass core.
// Holds the configuration register layout, register indexes and default sizes.
// No dependencies.
package fdca_pkg;

    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int DW_W        = 10;
    localparam int FRAC_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int RECIP_SHIFT = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_WHOLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FRACTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE    = 2'd3;

    localparam logic MODE_COMB    = 1'b0;
    localparam logic MODE_ALLPASS = 1'b1;

    typedef struct packed {
        logic [DW_W-1:0]          delay_whole;
        logic [FRAC_W-1:0]        delay_fraction;
        logic signed [GAIN_W-1:0] feedback_gain;
        logic                     filter_mode;
    } t_cfg;

endpackage

// ===== rtl/fdca_front.sv =====
// Front end of the fractional-delay core: accepts samples, numbers them with
// the write pointer and works out both tap addresses. Uses fdca_pkg.
module fdca_front #(
    parameter int STORE_DEPTH = fdca_pkg::DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS = fdca_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  fdca_pkg::t_cfg                                     i_cfg,
    input  logic                                               i_push,
    input  logic signed [SAMPLE_BITS-1:0]                      i_sample,
    output logic                                               o_full,
    output logic                                               o_job_push,
    output logic [SAMPLE_BITS+3*$clog2(STORE_DEPTH)-1:0]       o_job,
    input  logic                                               i_job_full
);
    import fdca_pkg::*;

    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int RECIP  = (1 << RECIP_SHIFT) / STORE_DEPTH;
    localparam int PROD_W = DW_W + RECIP_SHIFT;
    localparam int QN_W   = DW_W + AW + 1;
    localparam int RW     = (AW > DW_W) ? AW + 1 : DW_W + 1;

    logic                          r_a_valid;
    logic signed [SAMPLE_BITS-1:0] r_a_x;
    logic [DW_W-1:0]               r_a_dw;
    logic [DW_W-1:0]               r_a_q;
    logic [AW-1:0]                 r_a_wp;
    logic [AW-1:0]                 r_wp;

    logic              accept;
    logic [PROD_W-1:0] q_prod;
    logic [QN_W-1:0]   qn;
    logic [RW-1:0]     rem;
    logic [RW-1:0]     rem_fix;
    logic [AW-1:0]     d0;
    logic [AW:0]       diff;
    logic [AW-1:0]     ia;
    logic [AW-1:0]     ib;

    assign o_full     = r_a_valid && i_job_full;
    assign accept     = i_push && !o_full;
    assign o_job_push = r_a_valid && !i_job_full;

    // Quotient estimate by reciprocal; it is exact or one short.
    assign q_prod = PROD_W'(i_cfg.delay_whole) * PROD_W'(RECIP);

    always_comb begin
        qn      = QN_W'(r_a_q) * QN_W'(STORE_DEPTH);
        rem     = RW'(r_a_dw) - qn[RW-1:0];
        rem_fix = (rem >= RW'(STORE_DEPTH)) ? rem - RW'(STORE_DEPTH) : rem;
        d0      = rem_fix[AW-1:0];
        diff    = {1'b0, r_a_wp} - {1'b0, d0};
        if (diff[AW]) begin
            ia = AW'(diff + (AW+1)'(STORE_DEPTH));
        end else begin
            ia = diff[AW-1:0];
        end
        ib = (ia == '0) ? AW'(STORE_DEPTH - 1) : ia - 1'b1;
    end

    assign o_job = {r_a_x, ia, ib, r_a_wp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_wp      <= '0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                r_wp      <= (r_wp == AW'(STORE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end else if (o_job_push) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_x  <= i_sample;
            r_a_dw <= i_cfg.delay_whole;
            r_a_q  <= q_prod[PROD_W-1:RECIP_SHIFT];
            r_a_wp <= r_wp;
        end
    end

endmodule

// ===== rtl/fdca_queue.sv =====
// Short first-in first-out queue between the front and back of the core.
// Uses fdca_pkg for its default depth.
module fdca_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = fdca_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_rd;
    logic [PW-1:0]    r_wr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/fdca_back.sv =====
// Back end of the fractional-delay core: sample store, tap blend, feedback
// write and the result register. Uses fdca_pkg.
module fdca_back #(
    parameter int STORE_DEPTH = fdca_pkg::DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS = fdca_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  fdca_pkg::t_cfg                               i_cfg,
    input  logic [SAMPLE_BITS+3*$clog2(STORE_DEPTH)-1:0] i_job,
    input  logic                                         i_job_empty,
    output logic                                         o_job_pop,
    output logic signed [SAMPLE_BITS-1:0]                o_sample,
    output logic                                         o_empty,
    input  logic                                         i_pop
);
    import fdca_pkg::*;

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int JOB_W = SAMPLE_BITS + 3 * AW;
    localparam int PW    = SAMPLE_BITS + GAIN_W;
    localparam int MW    = SAMPLE_BITS + FRAC_W + 2;
    localparam int EW    = SAMPLE_BITS + 2;

    localparam logic signed [EW-1:0] SAT_HI =
        EW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);
    localparam logic signed [PW-1:0] Q15_HALF = PW'(16384);
    localparam logic signed [MW-1:0] Q16_HALF = MW'(32768);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD1  = 2'd1;
    localparam logic [1:0] S_MIX  = 2'd2;
    localparam logic [1:0] S_FB   = 2'd3;

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [SAMPLE_BITS-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[SAMPLE_BITS-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    logic signed [SAMPLE_BITS-1:0] r_mem [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rdata;
    logic                          r_rok;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic                          r_wrapped;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [AW-1:0]                 r_ib;
    logic [AW-1:0]                 r_wp;
    logic signed [SAMPLE_BITS-1:0] r_newer;
    logic signed [PW-1:0]          r_ffp;
    logic signed [SAMPLE_BITS-1:0] r_delayed;
    logic signed [SAMPLE_BITS:0]   r_ff;

    logic signed [SAMPLE_BITS-1:0] head_x;
    logic [AW-1:0]                 head_ia;
    logic [AW-1:0]                 head_ib;
    logic [AW-1:0]                 head_wp;

    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 rd_wp;
    logic                          rd_ok;
    logic signed [SAMPLE_BITS-1:0] tap;
    logic                          finish;

    logic signed [SAMPLE_BITS:0]   mix_diff;
    logic signed [MW-1:0]          mix_prod;
    logic signed [MW-1:0]          mix_sum;
    logic signed [PW-1:0]          ff_sum;
    logic signed [PW-1:0]          fb_prod;
    logic signed [PW-1:0]          fb_sum;
    logic signed [SAMPLE_BITS-1:0] wdata;
    logic signed [SAMPLE_BITS-1:0] y;

    assign head_x  = i_job[JOB_W-1 -: SAMPLE_BITS];
    assign head_ia = i_job[3*AW-1 -: AW];
    assign head_ib = i_job[2*AW-1 -: AW];
    assign head_wp = i_job[AW-1:0];

    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty;
    assign finish    = (r_state == S_FB) && (!r_out_valid || i_pop);
    assign o_empty   = !r_out_valid;
    assign o_sample  = r_out;

    // Entries below the current write pointer have been written since reset;
    // once the pointer has wrapped every entry holds a real sample.
    always_comb begin
        rd_en   = o_job_pop || (r_state == S_RD1);
        rd_addr = (r_state == S_IDLE) ? head_ia : r_ib;
        rd_wp   = (r_state == S_IDLE) ? head_wp : r_wp;
        rd_ok   = r_wrapped || (rd_addr < rd_wp);
        tap     = r_rok ? r_rdata : '0;
    end

    always_comb begin
        mix_diff = (SAMPLE_BITS+1)'(tap) - (SAMPLE_BITS+1)'(r_newer);
        mix_prod = MW'(mix_diff) * MW'($signed({1'b0, i_cfg.delay_fraction}));
        mix_sum  = (MW'(r_newer) <<< FRAC_W) + mix_prod + Q16_HALF;
        ff_sum   = r_ffp + Q15_HALF;
        fb_prod  = PW'(i_cfg.feedback_gain) * PW'(r_delayed);
        fb_sum   = fb_prod + Q15_HALF;
        wdata    = sat(EW'(r_x) + EW'($signed(fb_sum[PW-1:15])));
        if (i_cfg.filter_mode == MODE_ALLPASS) begin
            y = sat(EW'(r_delayed) - EW'(r_ff));
        end else begin
            y = r_delayed;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    n_state = S_RD1;
                end
            end
            S_RD1:   n_state = S_MIX;
            S_MIX:   n_state = S_FB;
            S_FB: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_out_valid <= 1'b1;
                if (r_wp == AW'(STORE_DEPTH - 1)) begin
                    r_wrapped <= 1'b1;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_x  <= head_x;
            r_ib <= head_ib;
            r_wp <= head_wp;
        end
        if (r_state == S_RD1) begin
            r_newer <= tap;
            r_ffp   <= PW'(i_cfg.feedback_gain) * PW'(r_x);
        end
        if (r_state == S_MIX) begin
            r_delayed <= mix_sum[SAMPLE_BITS+FRAC_W-1:FRAC_W];
            r_ff      <= ff_sum[PW-1:15];
        end
        if (finish) begin
            r_out <= y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_mem[r_wp] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_rok   <= rd_ok;
        end
    end

endmodule

// ===== rtl/fractional_delay_comb_allpass_core.sv =====
// Top level of the fractional-delay comb/allpass core.
// Holds the configuration registers and joins fdca_front, fdca_queue and
// fdca_back. Uses fdca_pkg.
//
// This core runs a Schroeder-style comb or allpass section on a stream of
// signed samples, with a delay of delay_whole + delay_fraction/65536 samples
// taken from a circular store of STORE_DEPTH entries. Samples enter through a
// queue-style port (push/full) and results leave through one (empty/pop), one
// result per sample, in order. The front end takes a sample in every cycle
// into its register, unless its register still holds one that the full queue
// cannot take, and works out the two tap addresses; a two-entry queue then
// hands the sample to the back end. The back end goes through S_IDLE, S_RD1,
// S_MIX and S_FB for each sample: two reads of the single-ported store (newer
// tap, then older tap), the linear blend, and the feedback multiply and the
// write back into the store, which must land before the next sample reads. The
// back end takes no new sample until that write is done.
// After reset the store reads as all zeros without any clearing pass: entries
// not yet written since reset are masked by a fill mark, so the first sample
// can be pushed right away. Configuration writes take effect at once and must
// only be made while no transaction is in flight.
module fractional_delay_comb_allpass_core #(
    parameter int STORE_DEPTH = fdca_pkg::DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS = fdca_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fdca_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [fdca_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                push,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    output logic                                full,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out
);
    import fdca_pkg::*;

    localparam int AW       = $clog2(STORE_DEPTH);
    localparam int JOB_W    = SAMPLE_BITS + 3 * AW;
    // Front register, queue entries, back end job and result register.
    localparam int CAPACITY = QUEUE_DEPTH + 3;
    localparam int IW       = $clog2(CAPACITY + 2);

    t_cfg             r_cfg;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_out;
    logic             job_push;
    logic             job_full;
    logic             job_pop;
    logic             job_empty;
    logic [IW-1:0]    r_inflight;
    logic             in_xfer;
    logic             out_xfer;

    // Configuration registers; an index outside the list cannot occur with a
    // two-bit address, but the default arm keeps any such write harmless.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_whole    <= DW_W'(1);
            r_cfg.delay_fraction <= '0;
            r_cfg.feedback_gain  <= '0;
            r_cfg.filter_mode    <= MODE_COMB;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DELAY_WHOLE:    r_cfg.delay_whole    <= i_cfg_data[DW_W-1:0];
                CFG_DELAY_FRACTION: r_cfg.delay_fraction <= i_cfg_data[FRAC_W-1:0];
                CFG_FEEDBACK_GAIN:  r_cfg.feedback_gain  <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_FILTER_MODE:    r_cfg.filter_mode    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    fdca_front #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_sample   (i_sample_in),
        .o_full     (full),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    fdca_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    fdca_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_sample    (o_sample_out),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    // Count of transactions accepted whose results have not yet been taken.
    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    // The pipeline never holds more samples than it has places for.
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= IW'(CAPACITY))
        else $error("more transactions in flight than the core can hold");

    // A waiting result always belongs to an accepted sample.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_inflight != '0))
        else $error("result offered with no transaction in flight");

    // With the queue empty, an accepted sample moves on and the port frees up.
    a_front_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && job_empty) |=> !full)
        else $error("front end stalled although the queue had room");

endmodule

// ===== tb/sv/fractional_delay_comb_allpass_core_tb.sv =====
// Self-checking testbench for fractional_delay_comb_allpass_core.
// Holds its own bit-exact model of the comb/allpass section and checks every result against it.
// Depends on fdca_pkg and the core RTL only.
`timescale 1ns / 1ps

module fractional_delay_comb_allpass_core_tb;

    import fdca_pkg::*;

    localparam int SB          = DEF_SAMPLE_BITS;
    localparam int DEPTH       = DEF_STORE_DEPTH;
    // Cycles without any transaction before the run is declared hung. The limit
    // leaves a wide margin over the slowest correct item.
    localparam int STALL_LIMIT = 2000;
    // Quiet cycles waited after the last result before the next register write.
    localparam int SETTLE      = 20;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_addr;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    push;
    logic signed [SB-1:0]    i_sample_in;
    logic                    full;
    logic                    empty;
    logic                    pop;
    logic signed [SB-1:0]    o_sample_out;

    fractional_delay_comb_allpass_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .i_sample_in  (i_sample_in),
        .full         (full),
        .empty        (empty),
        .pop          (pop),
        .o_sample_out (o_sample_out)
    );

    // Mirror of the core: the circular sample store, its write pointer and the
    // four configuration registers as the core holds them.
    logic signed [SB-1:0]     tap_store [DEPTH];
    logic [DW_W-1:0]          tap_wr_ptr;
    logic [DW_W-1:0]          cfg_whole;
    logic [FRAC_W-1:0]        cfg_frac;
    logic signed [GAIN_W-1:0] cfg_gain;
    logic                     cfg_mode;

    // Samples waiting to be pushed and filtered samples the core still owes.
    logic signed [SB-1:0]     samples_to_send [$];
    logic signed [SB-1:0]     out_samples_due [$];

    int queued_total;
    int checked_total;
    int mismatch_count;
    int quiet_cycles;
    int send_idle_max;
    int take_idle_max;
    int send_gap;
    int take_gap;
    logic sample_taken;
    logic result_taken;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [SB-1:0] clamp_sample(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[SB-1:0];
    endfunction

    // One filter step of the mirror. Both taps are read before the new value is
    // written, which is what makes a zero delay and a full-length delay read the
    // entry written one whole store length ago. All products are exact in 64 bits
    // and the arithmetic right shift of a signed longint is a floor division.
    function automatic logic signed [SB-1:0] run_filter_step(logic signed [SB-1:0] x);
        logic [DW_W-1:0] newer_idx;
        logic [DW_W-1:0] older_idx;
        longint newer;
        longint older;
        longint frac;
        longint gain;
        longint xin;
        longint delayed;
        longint fb;
        longint y;
        newer_idx = tap_wr_ptr - cfg_whole;
        older_idx = tap_wr_ptr - cfg_whole - 10'd1;
        newer = longint'(tap_store[newer_idx]);
        older = longint'(tap_store[older_idx]);
        frac  = longint'(cfg_frac);
        gain  = longint'(cfg_gain);
        xin   = longint'(x);
        delayed = (newer * (65536 - frac) + older * frac + 32768) >>> 16;
        fb = (gain * delayed + 16384) >>> 15;
        tap_store[tap_wr_ptr] = clamp_sample(xin + fb);
        tap_wr_ptr = tap_wr_ptr + 10'd1;
        if (cfg_mode == MODE_ALLPASS)
            y = longint'(clamp_sample(delayed - ((gain * xin + 16384) >>> 15)));
        else
            y = delayed;
        return y[SB-1:0];
    endfunction

    // Register writes are mirrored at the same clock edge the core takes them.
    // Bits above a register's width are dropped, as the core does.
    function automatic void mirror_reg_write(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DELAY_WHOLE:    cfg_whole = data[DW_W-1:0];
            CFG_DELAY_FRACTION: cfg_frac  = data[FRAC_W-1:0];
            CFG_FEEDBACK_GAIN:  cfg_gain  = data[GAIN_W-1:0];
            CFG_FILTER_MODE:    cfg_mode  = data[0];
            default: ;
        endcase
    endfunction

    // Handshake monitor, prediction and checking, all on the rising edge. The
    // result side is handled before the sample side so that a result can never
    // be matched against an expectation made in the same cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_taken <= 1'b0;
            result_taken <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            sample_taken <= push && !full;
            result_taken <= pop && !empty;
            if (pop && !empty) begin
                if (out_samples_due.size() == 0) begin
                    $display("%0t: unexpected result transaction, actual %0d",
                             $time, o_sample_out);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    if (o_sample_out !== out_samples_due[0]) begin
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, out_samples_due[0], o_sample_out);
                        mismatch_count <= mismatch_count + 1;
                    end
                    void'(out_samples_due.pop_front());
                    checked_total <= checked_total + 1;
                end
            end
            if (i_cfg_we)
                mirror_reg_write(i_cfg_addr, i_cfg_data);
            if (push && !full)
                out_samples_due.push_back(run_filter_step(i_sample_in));

            // Watchdog: any transaction or register write counts as progress.
            if ((push && !full) || (pop && !empty) || i_cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Sample driver. A presented sample stays on the port until it is taken;
    // after that the driver idles for the gap drawn with that sample.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || sample_taken) begin
            if (send_gap > 0) begin
                push <= 1'b0;
                send_gap = send_gap - 1;
            end else if (samples_to_send.size() != 0) begin
                i_sample_in <= samples_to_send.pop_front();
                push <= 1'b1;
                send_gap = $urandom_range(0, send_idle_max);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Result taker. Pop stays high until a result transaction completes, then
    // drops for a drawn number of cycles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (!pop || result_taken) begin
            if (take_gap > 0) begin
                pop <= 1'b0;
                take_gap = take_gap - 1;
            end else begin
                pop <= 1'b1;
                take_gap = $urandom_range(0, take_idle_max);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Writes all four registers. Unused upper data bits carry random values so
    // that every bit of the write data toggles.
    task automatic write_config(logic [DW_W-1:0] whole, logic [FRAC_W-1:0] frac,
                                logic [GAIN_W-1:0] gain, logic mode);
        logic [CFG_DATA_W-DW_W-1:0] whole_pad;
        logic [CFG_DATA_W-2:0]      mode_pad;
        whole_pad = (CFG_DATA_W-DW_W)'($urandom);
        mode_pad  = (CFG_DATA_W-1)'($urandom);
        write_reg(CFG_FILTER_MODE, {mode_pad, mode});
        write_reg(CFG_DELAY_WHOLE, {whole_pad, whole});
        write_reg(CFG_FEEDBACK_GAIN, gain);
        write_reg(CFG_DELAY_FRACTION, frac);
    endtask

    task automatic queue_sample(logic signed [SB-1:0] s);
        samples_to_send.push_back(s);
        queued_total = queued_total + 1;
    endtask

    // Waits until every queued sample has come back as a checked result, then
    // lets the pipeline settle so the core is idle for the next register write.
    task automatic drain();
        while (checked_total != queued_total)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic logic signed [SB-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return SB'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count, bit long_delay);
        logic [DW_W-1:0]   whole;
        logic [FRAC_W-1:0] frac;
        logic [GAIN_W-1:0] gain;
        // Most phases use short delays so that fresh samples echo back quickly;
        // some use the extremes and the whole delay range.
        if (long_delay) begin
            whole = DW_W'($urandom_range(900, DEPTH - 1));
        end else begin
            case ($urandom_range(0, 7))
                0:       whole = '0;
                1:       whole = DW_W'(DEPTH - 1);
                2:       whole = DW_W'($urandom);
                default: whole = DW_W'($urandom_range(1, 20));
            endcase
        end
        case ($urandom_range(0, 5))
            0:       frac = '0;
            1:       frac = 16'hFFFF;
            2:       frac = 16'h8000;
            default: frac = FRAC_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       gain = 16'h7FFF;
            1:       gain = 16'h8000;
            2:       gain = '0;
            default: gain = GAIN_W'($urandom);
        endcase
        write_config(whole, frac, gain, 1'($urandom_range(0, 1)));
        // Each side runs without idling in a quarter of the phases, drawn independently.
        send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
        take_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
        repeat (count) queue_sample(random_sample());
        drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = CFG_DELAY_WHOLE;
        i_cfg_data     = '0;
        push           = 1'b0;
        pop            = 1'b0;
        i_sample_in    = '0;
        queued_total   = 0;
        checked_total  = 0;
        mismatch_count = 0;
        send_gap       = 0;
        take_gap       = 0;
        send_idle_max  = 5;
        take_idle_max  = 5;
        // Reset state: cleared store, pointer at zero, delay of one sample,
        // no fraction, no gain, comb mode.
        for (int i = 0; i < DEPTH; i++)
            tap_store[i] = '0;
        tap_wr_ptr = '0;
        cfg_whole  = 10'd1;
        cfg_frac   = '0;
        cfg_gain   = '0;
        cfg_mode   = MODE_COMB;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: a plain one-sample delay. Field extremes and
        // alternating bit patterns go straight through.
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(16'sh0000);
        queue_sample(-16'sd1);
        queue_sample(16'sd1);
        queue_sample(16'sh5555);
        queue_sample(16'shAAAA);
        drain();

        // Allpass at full positive gain with a half-sample fraction: driving
        // full-scale samples saturates both the feedback and the output.
        write_config(10'd2, 16'h8000, 16'h7FFF, MODE_ALLPASS);
        queue_sample(16'sh7FFF);
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(16'sh8000);
        queue_sample(16'sd12345);
        queue_sample(16'sh0000);
        drain();

        // Zero delay reads the entry about to be overwritten, and the largest
        // fraction puts nearly all weight on the older tap.
        write_config(10'd0, 16'hFFFF, 16'h8000, MODE_COMB);
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(-16'sd300);
        queue_sample(16'sd300);
        queue_sample(16'sh1234);
        drain();

        // Full delay: the older tap wraps around onto the write pointer.
        write_config(10'(DEPTH - 1), 16'h0001, 16'h8000, MODE_ALLPASS);
        queue_sample(16'sh8000);
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(16'sd777);
        queue_sample(-16'sd777);
        queue_sample(16'sh4000);
        drain();

        repeat (10) random_phase(55, 1'b0);
        // By now the store holds hundreds of filtered samples, yet a delay near the
        // store length still reaches entries not yet written, which read as zeros.
        random_phase(250, 1'b1);

        if (mismatch_count == 0 && out_samples_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
